// ----- sv/msh_pkg.sv -----
`default_nettype none
package msh_pkg;

    // Field widths
    localparam int CTX_W  = 32;
    localparam int TIME_W = 64;
    localparam int POS_W  = 32;
    localparam int SPD_W  = 32;
    localparam int STAT_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W  = 32;

    // Defaults for the top level parameters
    localparam int TOKEN_WIDTH_DEF     = 32;
    localparam int ALPHA_FRAC_BITS_DEF = 16;

    // Sequencer step counts
    localparam int CNT_W       = 6;
    localparam int SQ_STEPS    = 3;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 64;
    localparam int HORN_FIRST  = 5;
    localparam int EXP_SQUARES = 10;
    localparam int EXP_SHIFT   = 10;

    localparam logic [29:0] NS_PER_S = 30'd1000000000;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] MAX_INTERVAL_RST = 32'd100000000;
    localparam logic [CFG_W-1:0] MAX_SPEED_RST    = 32'd3276800;
    localparam logic [CFG_W-1:0] TAU_RST          = 32'd100000000;
    localparam logic [CFG_W-1:0] START_THR_RST    = 32'd32768;
    localparam logic [CFG_W-1:0] STOP_THR_RST     = 32'd19661;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_INTERVAL = 3'd0,
        CFG_MAX_SPEED    = 3'd1,
        CFG_TAU          = 3'd2,
        CFG_START_THR    = 3'd3,
        CFG_STOP_THR     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] max_interval;
        logic [CFG_W-1:0] max_speed;
        logic [CFG_W-1:0] tau;
        logic [CFG_W-1:0] start_thr;
        logic [CFG_W-1:0] stop_thr;
    } t_cfg;

    typedef enum logic [STAT_W-1:0] {
        ST_UPDATED = 3'd0,
        ST_PRIMED  = 3'd1,
        ST_INVALID = 3'd2,
        ST_GAP     = 3'd3,
        ST_JUMP    = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLASSIFY, OP_SQ, OP_SQRT_INIT, OP_SQRT_STEP,
        OP_MUL_NS, OP_DIV_STEP, OP_JUDGE, OP_DIV_XQ, OP_HORN_INIT,
        OP_HORN_SUB, OP_HORN_MUL, OP_ESQ_INIT, OP_ESQ, OP_ALPHA,
        OP_FILT_MUL, OP_FILT_ADD, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic early;
        logic ovf;
        logic jump;
        logic asat;
        logic out_free;
    } t_sts;

    typedef enum logic [4:0] {
        S_IDLE, S_CLASS, S_SQ, S_SQI, S_SQRT, S_MULNS, S_DIV, S_JUDGE,
        S_DIVX, S_HINIT, S_HSUB, S_HMUL, S_ESQI, S_ESQ, S_ALPHA, S_FMUL,
        S_FADD, S_EMIT
    } t_state;

    // Truncating divide of a narrow value by 1..5, reciprocal multiply for 3 and 5
    function automatic logic [26:0] div_small(input logic [26:0] x, input logic [2:0] n);
        logic [58:0] p3;
        logic [58:0] p5;
        logic [26:0] q;
        p3 = 59'(x) * 59'(32'hAAAAAAAB);
        p5 = 59'(x) * 59'(32'hCCCCCCCD);
        unique case (n)
            3'd2:    q = x >> 1;
            3'd3:    q = 27'(p3 >> 33);
            3'd4:    q = x >> 2;
            3'd5:    q = 27'(p5 >> 34);
            default: q = x;
        endcase
        return q;
    endfunction

endpackage
`default_nettype wire

// ----- sv/msh_cfg.sv -----
`default_nettype none
module msh_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [msh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [msh_pkg::CFG_W-1:0]    i_cfg_data,
    output msh_pkg::t_cfg                     o_cfg
);
    import msh_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Write the addressed register, drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_interval <= MAX_INTERVAL_RST;
            r_cfg.max_speed    <= MAX_SPEED_RST;
            r_cfg.tau          <= TAU_RST;
            r_cfg.start_thr    <= START_THR_RST;
            r_cfg.stop_thr     <= STOP_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_INTERVAL: r_cfg.max_interval <= i_cfg_data;
                CFG_MAX_SPEED:    r_cfg.max_speed    <= i_cfg_data;
                CFG_TAU:          r_cfg.tau          <= i_cfg_data;
                CFG_START_THR:    r_cfg.start_thr    <= i_cfg_data;
                CFG_STOP_THR:     r_cfg.stop_thr     <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/msh_ctrl.sv -----
`default_nettype none
module msh_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  msh_pkg::t_sts      i_sts,
    output msh_pkg::t_cmd      o_cmd
);
    import msh_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_xq, n_xq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_xq    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_xq    <= n_xq;
        end
    end

    // Next state and step counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_xq    = r_xq;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CLASS;
            S_CLASS: begin
                n_cnt   = '0;
                n_state = i_sts.early ? S_EMIT : S_SQ;
            end
            S_SQ: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_STEPS - 1)) n_state = S_SQI;
            end
            S_SQI: begin
                n_cnt   = '0;
                n_state = i_sts.ovf ? S_EMIT : S_SQRT;
            end
            S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) n_state = S_MULNS;
            end
            S_MULNS: begin
                n_cnt   = '0;
                n_xq    = 1'b0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = r_xq ? S_HINIT : S_JUDGE;
            end
            S_JUDGE: begin
                if (i_sts.jump)      n_state = S_EMIT;
                else if (i_sts.asat) n_state = S_FMUL;
                else                 n_state = S_DIVX;
            end
            S_DIVX: begin
                n_cnt   = '0;
                n_xq    = 1'b1;
                n_state = S_DIV;
            end
            S_HINIT: begin
                n_cnt   = CNT_W'(HORN_FIRST);
                n_state = S_HSUB;
            end
            S_HSUB: begin
                n_cnt   = r_cnt - 1'b1;
                n_state = (r_cnt == CNT_W'(1)) ? S_ESQI : S_HMUL;
            end
            S_HMUL:  n_state = S_HSUB;
            S_ESQI: begin
                n_cnt   = '0;
                n_state = S_ESQ;
            end
            S_ESQ: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(EXP_SQUARES - 1)) n_state = S_ALPHA;
            end
            S_ALPHA: n_state = S_FMUL;
            S_FMUL:  n_state = S_FADD;
            S_FADD:  n_state = S_EMIT;
            S_EMIT:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.idx  = r_cnt[2:0];
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_CLASS: o_cmd.op = OP_CLASSIFY;
            S_SQ:    o_cmd.op = OP_SQ;
            S_SQI:   o_cmd.op = OP_SQRT_INIT;
            S_SQRT:  o_cmd.op = OP_SQRT_STEP;
            S_MULNS: o_cmd.op = OP_MUL_NS;
            S_DIV:   o_cmd.op = OP_DIV_STEP;
            S_JUDGE: o_cmd.op = OP_JUDGE;
            S_DIVX:  o_cmd.op = OP_DIV_XQ;
            S_HINIT: o_cmd.op = OP_HORN_INIT;
            S_HSUB:  o_cmd.op = OP_HORN_SUB;
            S_HMUL:  o_cmd.op = OP_HORN_MUL;
            S_ESQI:  o_cmd.op = OP_ESQ_INIT;
            S_ESQ:   o_cmd.op = OP_ESQ;
            S_ALPHA: o_cmd.op = OP_ALPHA;
            S_FMUL:  o_cmd.op = OP_FILT_MUL;
            S_FADD:  o_cmd.op = OP_FILT_ADD;
            S_EMIT:  if (i_sts.out_free) o_cmd.op = OP_EMIT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/msh_dp.sv -----
`default_nettype none
module msh_dp #(
    parameter int TOKEN_WIDTH     = msh_pkg::TOKEN_WIDTH_DEF,
    parameter int ALPHA_FRAC_BITS = msh_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  msh_pkg::t_cmd                   i_cmd,
    output msh_pkg::t_sts                   o_sts,
    input  msh_pkg::t_cfg                   i_cfg,
    input  wire logic                       i_sample_ok,
    input  wire logic [msh_pkg::CTX_W-1:0]  i_context_id,
    input  wire logic signed [msh_pkg::TIME_W-1:0] i_display_time_ns,
    input  wire logic signed [msh_pkg::POS_W-1:0]  i_pos_x,
    input  wire logic signed [msh_pkg::POS_W-1:0]  i_pos_y,
    input  wire logic signed [msh_pkg::POS_W-1:0]  i_pos_z,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_moving_target,
    output logic [msh_pkg::SPD_W-1:0]       o_speed_out,
    output logic [msh_pkg::STAT_W-1:0]      o_step_status
);
    import msh_pkg::*;

    localparam int TOK_W = (TOKEN_WIDTH < CTX_W) ? TOKEN_WIDTH : CTX_W;
    localparam int AF    = ALPHA_FRAC_BITS;
    localparam logic [32:0] ONE = 33'h1_0000_0000;

    // Captured sample
    logic                    r_in_ok;
    logic [CTX_W-1:0]        r_in_ctx;
    logic [TIME_W-1:0]       r_in_tm;
    logic [POS_W-1:0]        r_in_pos [3];

    // Tracking state
    logic                    r_have;
    logic [TOK_W-1:0]        r_last_ctx;
    logic [TIME_W-1:0]       r_last_tm;
    logic [POS_W-1:0]        r_last_pos [3];
    logic [SPD_W-1:0]        r_s;
    logic                    r_mov;

    // Work registers
    logic [POS_W-1:0]        r_d [3];
    logic [31:0]             r_dt;
    logic [65:0]             r_sum;
    logic [63:0]             r_sv, r_sr, r_sb;
    logic [63:0]             r_dq;
    logic [31:0]             r_rem, r_dvs;
    logic [SPD_W-1:0]        r_speed;
    logic [26:0]             r_t, r_p;
    logic [32:0]             r_h;
    logic [31:0]             r_e;
    logic [AF-1:0]           r_alpha;
    logic                    r_up;
    logic [31:0]             r_step;

    // Pending result and output stage
    logic                    r_res_mov;
    logic [SPD_W-1:0]        r_res_spd;
    t_status                 r_res_st;
    logic                    r_ov;
    logic                    r_o_mov;
    logic [SPD_W-1:0]        r_o_spd;
    t_status                 r_o_st;

    // Classification of the captured sample
    logic                    in_good, new_ctx, gap, clr;
    logic [TOK_W-1:0]        tok;
    logic [TIME_W-1:0]       dt_full;
    logic [POS_W-1:0]        d_abs [3];
    logic                    ovf, jump, asat;

    assign tok     = r_in_ctx[TOK_W-1:0];
    assign in_good = r_in_ok && (tok != '0) && (r_in_tm != '0) && !r_in_tm[TIME_W-1];
    assign new_ctx = !r_have || (r_last_ctx != tok);
    assign dt_full = (r_in_tm > r_last_tm) ? (r_in_tm - r_last_tm) : '0;
    assign gap     = (dt_full == '0) || (dt_full > TIME_W'(i_cfg.max_interval));
    assign ovf     = (r_sum[65:64] != 2'b00) || (&r_sum[63:0]);
    assign jump    = r_dq > 64'(i_cfg.max_speed);
    assign asat    = (i_cfg.tau == '0) || ({5'b0, r_dt} >= {i_cfg.tau, 5'b0});

    always_comb begin
        logic signed [POS_W:0] diff;
        for (int k = 0; k < 3; k++) begin
            diff = $signed({r_in_pos[k][POS_W-1], r_in_pos[k]})
                 - $signed({r_last_pos[k][POS_W-1], r_last_pos[k]});
            d_abs[k] = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
        end
    end

    assign clr = ((i_cmd.op == OP_CLASSIFY) && !in_good)
              || ((i_cmd.op == OP_SQRT_INIT) && ovf)
              || ((i_cmd.op == OP_JUDGE) && jump);

    assign o_sts.early    = !in_good || new_ctx || gap;
    assign o_sts.ovf      = ovf;
    assign o_sts.jump     = jump;
    assign o_sts.asat     = asat;
    assign o_sts.out_free = !r_ov || i_out_ready;

    // Shared multiplier
    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_SQ: begin
                mul_a = 33'(r_d[i_cmd.idx[1:0]]);
                mul_b = 33'(r_d[i_cmd.idx[1:0]]);
            end
            OP_MUL_NS: begin
                mul_a = 33'(r_sr[31:0]);
                mul_b = 33'(NS_PER_S);
            end
            OP_HORN_MUL: begin
                mul_a = 33'(r_t);
                mul_b = r_h;
            end
            OP_ESQ: begin
                mul_a = 33'(r_e);
                mul_b = 33'(r_e);
            end
            OP_FILT_MUL: begin
                mul_a = r_up ? 33'(r_speed - r_s) : 33'(r_s - r_speed);
                mul_b = 33'(r_alpha);
            end
            default: ;
        endcase
        mul_p = 66'(mul_a) * 66'(mul_b);
    end

    // Root step, divide step, alpha and filter terms
    logic [64:0] sq_trial;
    logic [32:0] dv_sh;
    logic [32:0] a_sh;
    logic [SPD_W-1:0] s_new;
    logic        mov_new;

    assign sq_trial = 65'(r_sr) + 65'(r_sb);
    assign dv_sh    = {r_rem, r_dq[63]};
    assign a_sh     = (ONE - 33'(r_e)) >> (32 - AF);
    assign s_new    = r_up ? (r_s + r_step) : (r_s - r_step);
    assign mov_new  = r_mov ? (s_new > i_cfg.stop_thr) : (s_new >= i_cfg.start_thr);

    // Capture the sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_in_ok     <= i_sample_ok;
            r_in_ctx    <= i_context_id;
            r_in_tm     <= i_display_time_ns;
            r_in_pos[0] <= i_pos_x;
            r_in_pos[1] <= i_pos_y;
            r_in_pos[2] <= i_pos_z;
        end
    end

    // Tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            r_have     <= 1'b0;
            r_last_ctx <= '0;
            r_last_tm  <= '0;
            r_last_pos <= '{default: '0};
            r_s        <= '0;
            r_mov      <= 1'b0;
        end else if (i_cmd.op == OP_CLASSIFY) begin
            r_last_tm  <= r_in_tm;
            r_last_pos <= r_in_pos;
            if (new_ctx) begin
                r_have     <= 1'b1;
                r_last_ctx <= tok;
            end else if (gap) begin
                r_s   <= '0;
                r_mov <= 1'b0;
            end
        end else if (i_cmd.op == OP_FILT_ADD) begin
            r_s   <= s_new;
            r_mov <= mov_new;
        end
    end

    // Arithmetic work registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CLASSIFY: begin
                r_d   <= d_abs;
                r_dt  <= dt_full[31:0];
                r_sum <= '0;
            end
            OP_SQ: r_sum <= r_sum + mul_p;
            OP_SQRT_INIT: begin
                r_sv <= r_sum[63:0];
                r_sr <= '0;
                r_sb <= 64'd1 << 62;
            end
            OP_SQRT_STEP: begin
                if ({1'b0, r_sv} >= sq_trial) begin
                    r_sv <= r_sv - sq_trial[63:0];
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb <= r_sb >> 2;
            end
            OP_MUL_NS: begin
                r_dq  <= mul_p[63:0];
                r_rem <= '0;
                r_dvs <= r_dt;
            end
            OP_DIV_XQ: begin
                r_dq  <= {r_dt, 32'b0};
                r_rem <= '0;
                r_dvs <= i_cfg.tau;
            end
            OP_DIV_STEP: begin
                if (dv_sh >= {1'b0, r_dvs}) begin
                    r_rem <= 32'(dv_sh - {1'b0, r_dvs});
                    r_dq  <= {r_dq[62:0], 1'b1};
                end else begin
                    r_rem <= dv_sh[31:0];
                    r_dq  <= {r_dq[62:0], 1'b0};
                end
            end
            OP_JUDGE: begin
                r_speed <= r_dq[SPD_W-1:0];
                r_alpha <= '1;
            end
            OP_HORN_INIT: begin
                r_t <= r_dq[EXP_SHIFT+26:EXP_SHIFT];
                r_p <= r_dq[EXP_SHIFT+26:EXP_SHIFT];
            end
            OP_HORN_SUB: r_h <= ONE - 33'(div_small(r_p, i_cmd.idx));
            OP_HORN_MUL: r_p <= mul_p[58:32];
            OP_ESQ_INIT: r_e <= r_h[32] ? 32'hFFFF_FFFF : r_h[31:0];
            OP_ESQ:      r_e <= mul_p[63:32];
            OP_ALPHA:    r_alpha <= (|a_sh[32:AF]) ? '1 : a_sh[AF-1:0];
            OP_FILT_MUL: r_step <= mul_p[AF+31:AF];
            default: ;
        endcase
        if (i_cmd.op == OP_JUDGE) r_up <= r_dq[SPD_W-1:0] >= r_s;
    end

    // Pending result
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CLASSIFY: begin
                r_res_mov <= 1'b0;
                if (!in_good) begin
                    r_res_spd <= '0;
                    r_res_st  <= ST_INVALID;
                end else if (new_ctx) begin
                    r_res_spd <= r_s;
                    r_res_st  <= ST_PRIMED;
                end else begin
                    r_res_spd <= '0;
                    r_res_st  <= ST_GAP;
                end
            end
            OP_SQRT_INIT, OP_JUDGE: begin
                r_res_mov <= 1'b0;
                r_res_spd <= '0;
                r_res_st  <= ST_JUMP;
            end
            OP_FILT_ADD: begin
                r_res_mov <= mov_new;
                r_res_spd <= s_new;
                r_res_st  <= ST_UPDATED;
            end
            default: ;
        endcase
    end

    // Output stage: hold a beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_o_mov <= r_res_mov;
            r_o_spd <= r_res_spd;
            r_o_st  <= r_res_st;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_moving_target = r_o_mov;
    assign o_speed_out     = r_o_spd;
    assign o_step_status   = r_o_st;

endmodule
`default_nettype wire

// ----- sv/motion_speed_hysteresis_detector_top.sv -----
// Motion speed detector with hysteresis.
// Input channel (i_in_valid / o_in_ready) takes one timestamped position
// sample per beat; output channel (o_out_valid / i_out_ready) returns one
// result beat per sample: moving flag, filtered speed and step status.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes one 32-bit
// register per beat; o_cfg_ready is always high. Write only while idle.
// One sample is processed at a time. Invalid, primed and gap samples go
// from the classify state straight to the emit state. A full update runs
// 3 squaring steps, a 32-step square root, two 64-step restoring divides
// (speed and dt/tau) on one shared divider, an exponential series
// and 10 squarings on one shared multiplier. When the time ratio saturates
// alpha, the second divide and the exponential are skipped. A result waits
// in the output register while the receiver stalls; the next sample is
// accepted once that result has been loaded.
// Reset clears the tracking state and loads the register defaults.
`default_nettype none
module motion_speed_hysteresis_detector_top #(
    parameter int TOKEN_WIDTH     = msh_pkg::TOKEN_WIDTH_DEF,
    parameter int ALPHA_FRAC_BITS = msh_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_sample_ok,
    input  wire logic [msh_pkg::CTX_W-1:0]          i_context_id,
    input  wire logic signed [msh_pkg::TIME_W-1:0]  i_display_time_ns,
    input  wire logic signed [msh_pkg::POS_W-1:0]   i_pos_x,
    input  wire logic signed [msh_pkg::POS_W-1:0]   i_pos_y,
    input  wire logic signed [msh_pkg::POS_W-1:0]   i_pos_z,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_moving_target,
    output logic [msh_pkg::SPD_W-1:0]               o_speed_out,
    output logic [msh_pkg::STAT_W-1:0]              o_step_status,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [msh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [msh_pkg::CFG_W-1:0]          i_cfg_data
);
    import msh_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    msh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    msh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    msh_dp #(
        .TOKEN_WIDTH     (TOKEN_WIDTH),
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg             (cfg),
        .i_sample_ok       (i_sample_ok),
        .i_context_id      (i_context_id),
        .i_display_time_ns (i_display_time_ns),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_moving_target   (o_moving_target),
        .o_speed_out       (o_speed_out),
        .o_step_status     (o_step_status)
    );

endmodule
`default_nettype wire
